[rtl/core/sine_tone_generator_unit_assert.svh]
// Assertion macros for the sine tone generator checker.
// No dependencies; include by bare file name.
`ifndef SINE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define SINE_TONE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is low.
`define STG_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error("stg check failed");

// Next-cycle implication, disabled while rst is low.
`define STG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error("stg check failed");

`endif

[rtl/core/stg_pkg.sv]
// Shared types, constants and the quarter-wave sine table function
// for the sine tone generator. No dependencies.
package stg_pkg;

  // Defaults for the top-level parameters
  localparam int TableAddrBitsDefault = 10;
  localparam int PhaseBitsDefault     = 32;

  // Field and register widths
  localparam int PhaseStepW   = 32;
  localparam int AmplitudeW   = 15;
  localparam int SampleCountW = 24;
  localparam int SampleW      = 16;
  localparam int TableW       = 15;
  localparam int ProdW        = AmplitudeW + TableW;
  localparam int CfgIndexW    = 2;
  localparam int CfgDataW     = 32;

  // Full-scale value of a table entry and of the output divisor
  localparam logic [TableW-1:0] FullScale = 15'd32767;

  // Depth of the request queue between front and back
  localparam int QueueDepth = 4;

  // pi/2 in Q2.30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_AMPLITUDE    = 2'd1,
    CFG_SAMPLE_COUNT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PhaseStepW-1:0]   phase_step;
    logic [AmplitudeW-1:0]   amplitude;
    logic [SampleCountW-1:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Quarter-wave sine entry in Q0.15: Taylor series up to x^17 in Q2.30,
  // evaluated at elaboration only.
  function automatic logic [TableW-1:0] quarter_sine(input int unsigned idx,
                                                     input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (HalfPiQ30 * 64'(idx)) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[TableW-1:0];
  endfunction

endpackage

[rtl/core/stg_if.sv]
// Valid/ready channel interfaces for tick requests and PCM results.
// Depends on stg_pkg for the sample width.
interface stg_in_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stg_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [stg_pkg::SampleW-1:0]  sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

[rtl/core/stg_queue.sv]
// Short request queue between the phase front end and the sample back end.
// Depends on stg_pkg for depth and status type.
module stg_queue #(
  parameter int DATA_W = stg_pkg::TableAddrBitsDefault + 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output stg_pkg::q_status_t status
);

  localparam int PtrW = $clog2(stg_pkg::QueueDepth);
  localparam int CntW = $clog2(stg_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(stg_pkg::QueueDepth);

  logic [DATA_W-1:0] mem [stg_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push;
  logic              do_pop;

  // Drop a push into a full queue, a pop from an empty one
  assign do_push = push && (count_r != DepthCnt);
  assign do_pop  = pop && (count_r != '0);

  assign status.full  = (count_r == DepthCnt);
  assign status.empty = (count_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/stg_front.sv]
// Front end: accepts ticks, runs the phase accumulator and burst counter,
// and queues one lookup request per emitted sample. Depends on stg_pkg, stg_if.
module stg_front #(
  parameter int TABLE_ADDRESS_BITS = stg_pkg::TableAddrBitsDefault,
  parameter int PHASE_BITS         = stg_pkg::PhaseBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stg_in_if.sink                          in_chan,
  input  stg_pkg::cfg_t                   cfg,
  input  stg_pkg::q_status_t              q_status,
  output logic                            push,
  output logic [TABLE_ADDRESS_BITS+2:0]   push_data
);

  logic [PHASE_BITS-1:0]            phase_r;
  logic [PHASE_BITS-1:0]            phase_nxt;
  logic [stg_pkg::SampleCountW-1:0] count_r;
  logic [stg_pkg::SampleCountW-1:0] count_nxt;
  logic [PHASE_BITS-1:0]            eff_phase;
  logic [stg_pkg::SampleCountW-1:0] eff_count;
  logic [stg_pkg::SampleCountW-1:0] count_inc;
  logic [PHASE_BITS+31:0]           step_wide;
  logic [PHASE_BITS-1:0]            step_aligned;
  logic                             accept;
  logic                             emit;
  logic                             last;

  assign in_chan.ready = !q_status.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Align the 32-bit step to the accumulator width
  assign step_wide    = {cfg.phase_step, PHASE_BITS'(0)};
  assign step_aligned = step_wide[PHASE_BITS+31:32];

  // Apply restart, then classify the tick as emitting or finished
  always_comb begin
    eff_phase = in_chan.restart ? '0 : phase_r;
    eff_count = in_chan.restart ? '0 : count_r;
    count_inc = eff_count + stg_pkg::SampleCountW'(1);
    emit      = (eff_count < cfg.sample_count);
    last      = (count_inc == cfg.sample_count);
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (accept) begin
      phase_nxt = emit ? eff_phase + step_aligned : eff_phase;
      count_nxt = emit ? count_inc : eff_count;
    end
  end

  // Queue quadrant, table index and last mark of the current phase
  assign push      = accept && emit;
  assign push_data = {last, eff_phase[PHASE_BITS-1 -: 2],
                      eff_phase[PHASE_BITS-3 -: TABLE_ADDRESS_BITS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/core/stg_back.sv]
// Back end: quarter-wave ROM read, amplitude multiply, divide by full scale
// and output register. Depends on stg_pkg, stg_if.
module stg_back #(
  parameter int TABLE_ADDRESS_BITS = stg_pkg::TableAddrBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stg_pkg::cfg_t                 cfg,
  input  stg_pkg::q_status_t            q_status,
  input  logic [TABLE_ADDRESS_BITS+2:0] pop_data,
  output logic                          pop,
  stg_out_if.source                     out_chan
);

  localparam int TW         = stg_pkg::TableW;
  localparam int PW         = stg_pkg::ProdW;
  localparam int SW         = stg_pkg::SampleW;
  localparam int QuarterLen = 1 << TABLE_ADDRESS_BITS;
  localparam logic [TABLE_ADDRESS_BITS:0] QuarterAddr = {1'b1, {TABLE_ADDRESS_BITS{1'b0}}};

  logic [TW-1:0]                 rom [QuarterLen+1];
  logic [TABLE_ADDRESS_BITS-1:0] idx;
  logic [TABLE_ADDRESS_BITS:0]   rom_addr;
  logic                          en;

  logic          v1_r, v2_r, v3_r, out_valid_r;
  logic [TW-1:0] rom_r;
  logic [PW-1:0] prod_r;
  logic [TW-1:0] quot_r;
  logic [SW-1:0] rem_r;
  logic          neg1_r, neg2_r, neg3_r;
  logic          last1_r, last2_r, last3_r, last_r;
  logic signed [SW-1:0] sample_r;

  logic [PW:0]   est_sum;
  logic [TW-1:0] quot_est;
  logic [PW-1:0] quot_times;
  logic [PW-1:0] rem_full;
  logic [SW-1:0] mag;

  // Fill the ROM with elaboration-time constants
  for (genvar g = 0; g <= QuarterLen; g++) begin : g_rom
    localparam logic [TW-1:0] Entry = stg_pkg::quarter_sine(g, TABLE_ADDRESS_BITS);
    assign rom[g] = Entry;
  end

  // Stall every stage while the output holds an untaken sample
  assign en  = !out_valid_r || out_chan.ready;
  assign pop = en && !q_status.empty;

  // Mirror the index in odd quadrants
  assign idx      = pop_data[TABLE_ADDRESS_BITS-1:0];
  assign rom_addr = pop_data[TABLE_ADDRESS_BITS] ? QuarterAddr - {1'b0, idx} : {1'b0, idx};

  // Estimate prod / 32767 from below, within one, and keep the remainder
  always_comb begin
    est_sum    = {1'b0, prod_r} + (PW + 1)'(prod_r >> TW);
    quot_est   = est_sum[PW-1:TW];
    quot_times = {quot_est, TW'(0)} - PW'(quot_est);
    rem_full   = prod_r - quot_times;
  end

  // Correct the quotient by one; the output register applies the quadrant sign
  assign mag = {1'b0, quot_r} + SW'(rem_r >= SW'(stg_pkg::FullScale));

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      rom_r    <= rom[rom_addr];
      neg1_r   <= pop_data[TABLE_ADDRESS_BITS+1];
      last1_r  <= pop_data[TABLE_ADDRESS_BITS+2];
      prod_r   <= {{(PW-stg_pkg::AmplitudeW){1'b0}}, cfg.amplitude} * {{(PW-TW){1'b0}}, rom_r};
      neg2_r   <= neg1_r;
      last2_r  <= last1_r;
      quot_r   <= quot_est;
      rem_r    <= rem_full[SW-1:0];
      neg3_r   <= neg2_r;
      last3_r  <= last2_r;
      sample_r <= neg3_r ? -signed'(mag) : signed'(mag);
      last_r   <= last3_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = sample_r;
  assign out_chan.last   = last_r;

endmodule

[rtl/core/sine_tone_generator_unit.sv]
// Top level of the sine tone generator: configuration registers, front end,
// request queue and back end. Depends on stg_pkg, stg_if, stg_front, stg_queue, stg_back.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        restart
//   out_chan  out  valid/ready        sample (s16), last
//   cfg_*     in   cfg_we, no ready   cfg_index, cfg_wdata
//
// One tick per cycle is accepted while the queue is not full, and one sample per
// cycle is delivered while the output is taken. A tick is written to the queue at
// the accepting edge, then passes the ROM read, multiply, quotient estimate and
// corrected output register. The phase add is combinational; the queue has four entries.
// Reset is synchronous and active low; it clears phase, burst count and configuration registers.
// A stalled output freezes the back end; the front keeps taking ticks until the
// queue fills.
module sine_tone_generator_unit #(
  parameter int TABLE_ADDRESS_BITS = stg_pkg::TableAddrBitsDefault,
  parameter int PHASE_BITS         = stg_pkg::PhaseBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  stg_in_if.sink                         in_chan,
  stg_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [stg_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [stg_pkg::CfgDataW-1:0]   cfg_wdata
);

  localparam int ReqW = TABLE_ADDRESS_BITS + 3;

  stg_pkg::cfg_t      cfg_r;
  stg_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic [ReqW-1:0]    push_data;
  logic [ReqW-1:0]    pop_data;

  // Decode register writes; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stg_pkg::CFG_PHASE_STEP: begin
          cfg_r.phase_step <= cfg_wdata[stg_pkg::PhaseStepW-1:0];
        end
        stg_pkg::CFG_AMPLITUDE: begin
          cfg_r.amplitude <= cfg_wdata[stg_pkg::AmplitudeW-1:0];
        end
        stg_pkg::CFG_SAMPLE_COUNT: begin
          cfg_r.sample_count <= cfg_wdata[stg_pkg::SampleCountW-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  stg_front #(
    .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS),
    .PHASE_BITS         (PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  stg_queue #(
    .DATA_W (ReqW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  stg_back #(
    .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_status (q_status),
    .pop_data (pop_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

[rtl/core/stg_checker.sv]
// Port-level checks for the sine tone generator, bound to the top level.
// Depends on stg_pkg and sine_tone_generator_unit_assert.svh.
`include "sine_tone_generator_unit_assert.svh"

module stg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [stg_pkg::SampleW-1:0]  sample,
  input logic                                last,
  input logic                                cfg_we,
  input logic [stg_pkg::CfgIndexW-1:0]       cfg_index,
  input logic [stg_pkg::CfgDataW-1:0]        cfg_wdata
);

  logic [stg_pkg::AmplitudeW-1:0]   amp_r;
  logic [stg_pkg::SampleCountW-1:0] cnt_r;
  logic signed [stg_pkg::SampleW:0] amp_s;
  logic signed [stg_pkg::SampleW:0] sample_s;

  // Track amplitude and burst length as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= '0;
      cnt_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == stg_pkg::CFG_AMPLITUDE) begin
        amp_r <= cfg_wdata[stg_pkg::AmplitudeW-1:0];
      end
      if (cfg_index == stg_pkg::CFG_SAMPLE_COUNT) begin
        cnt_r <= cfg_wdata[stg_pkg::SampleCountW-1:0];
      end
    end
  end

  assign amp_s    = signed'({2'b00, amp_r});
  assign sample_s = (stg_pkg::SampleW + 1)'(sample);

  `STG_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_valid)
  `STG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(last))
  `STG_ASSERT_IMPL(a_amp_bound, clk, rst_n, out_valid, (sample_s <= amp_s) && (sample_s >= -amp_s))
  `STG_ASSERT_IMPL(a_single_last, clk, rst_n, out_valid && (cnt_r == 24'd1), last)

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .sample    (out_chan.sample),
  .last      (out_chan.last),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

[tb/sine_tone_generator_unit_tb.sv]
// Self-checking testbench for sine_tone_generator_unit: drives tick requests and
// register writes, predicts every PCM sample and the burst-end mark, checks results.
// Depends on stg_pkg, stg_if and the RTL of the block.
module sine_tone_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableBits   = 10;
  localparam int PhaseBits   = 32;
  localparam int QuarterSize = 1 << TableBits;
  localparam logic [63:0] AngleQuarterTurn = 64'd1686629713;  // pi/2 in Q2.30
  localparam logic [stg_pkg::CfgIndexW-1:0] CfgSpareIndex = 2'd3;  // no register behind it
  localparam int RandomGoal  = 1500;
  localparam int HoldCycles  = 64;
  localparam int DrainCycles = 12;
  localparam int TailCycles  = 20;
  localparam int StallLimit  = 2000;

  typedef struct {
    logic signed [stg_pkg::SampleW-1:0] sample;
    logic                               last;
  } pcm_t;

  // Predicts the burst of samples and holds the samples still owed by the block
  class pcm_burst_tracker;
    logic [stg_pkg::TableW-1:0]       quarter_wave [0:QuarterSize];
    logic [stg_pkg::PhaseStepW-1:0]   step_reg;
    logic [stg_pkg::AmplitudeW-1:0]   amp_reg;
    logic [stg_pkg::SampleCountW-1:0] count_reg;
    logic [PhaseBits-1:0]             phase_acc;
    logic [stg_pkg::SampleCountW-1:0] emitted;
    pcm_t pcm_due [$];
    int mismatches, checked, lasts, ticks, restarts;

    function new();
      for (int i = 0; i <= QuarterSize; i++) begin
        quarter_wave[i] = sine_entry(i);
      end
      step_reg  = '0;
      amp_reg   = '0;
      count_reg = '0;
      phase_acc = '0;
      emitted   = '0;
    endfunction

    // Q0.15 sine of a quarter-wave slot, Taylor series in Q2.30
    function automatic logic [stg_pkg::TableW-1:0] sine_entry(int unsigned i);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      longint      acc;
      longint      rounded;
      ang    = (AngleQuarterTurn * 64'(i)) >> TableBits;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      rounded = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
      if (rounded > 32767) rounded = 32767;
      return rounded[stg_pkg::TableW-1:0];
    endfunction

    function void write_reg(logic [stg_pkg::CfgIndexW-1:0] idx,
                            logic [stg_pkg::CfgDataW-1:0] data);
      case (idx)
        stg_pkg::CFG_PHASE_STEP:   step_reg  = data[stg_pkg::PhaseStepW-1:0];
        stg_pkg::CFG_AMPLITUDE:    amp_reg   = data[stg_pkg::AmplitudeW-1:0];
        stg_pkg::CFG_SAMPLE_COUNT: count_reg = data[stg_pkg::SampleCountW-1:0];
        default: ;
      endcase
    endfunction

    function bit burst_done();
      return emitted >= count_reg;
    endfunction

    // Advance the oscillator by one accepted tick; return 1 if a sample is owed
    function bit note_tick(logic restart);
      pcm_t            p;
      logic [1:0]      quad;
      logic [TableBits-1:0] slot;
      int unsigned     addr;
      logic [31:0]     mag;
      ticks++;
      if (restart) begin
        phase_acc = '0;
        emitted   = '0;
        restarts++;
      end
      if (emitted >= count_reg) return 0;
      quad = phase_acc[PhaseBits-1 -: 2];
      slot = phase_acc[PhaseBits-3 -: TableBits];
      addr = quad[0] ? QuarterSize - slot : slot;
      mag  = (32'(amp_reg) * 32'(quarter_wave[addr])) / 32'd32767;
      p.sample  = quad[1] ? -16'(mag) : 16'(mag);
      phase_acc = phase_acc + step_reg;
      emitted   = emitted + 1'b1;
      p.last    = (emitted == count_reg);
      pcm_due.push_back(p);
      return 1;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_sample(logic signed [stg_pkg::SampleW-1:0] sample, logic last);
      pcm_t want;
      if (pcm_due.size() == 0) begin
        flag($sformatf("unexpected sample %0d last %0b", sample, last));
        return;
      end
      want = pcm_due.pop_front();
      checked++;
      if (last) lasts++;
      if (sample !== want.sample || last !== want.last) begin
        flag($sformatf("sample #%0d: expected %0d last %0b, got %0d last %0b",
                       checked, want.sample, want.last, sample, last));
      end
    endfunction

    function bit clean();
      if (pcm_due.size() != 0) begin
        flag($sformatf("%0d expected samples never arrived", pcm_due.size()));
      end
      return mismatches == 0;
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [stg_pkg::CfgIndexW-1:0] cfg_index;
  logic [stg_pkg::CfgDataW-1:0]  cfg_wdata;
  stg_in_if  in_ch ();
  stg_out_if out_ch ();

  pcm_burst_tracker tracker = new();
  bit hold_request;
  bit sender_eager;
  bit receiver_eager;
  int produced;
  int settings;
  int quiet_cycles;

  sine_tone_generator_unit #(
    .TABLE_ADDRESS_BITS(TableBits),
    .PHASE_BITS        (PhaseBits)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one tick request after a random gap and hold it until accepted
  task automatic send_tick(input logic restart_bit);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart_bit;
    do @(posedge clk); while (!in_ch.ready);
    if (tracker.note_tick(restart_bit)) produced++;
    @(negedge clk);
  endtask

  // Drop the request line, wait for every owed sample, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pcm_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [stg_pkg::CfgIndexW-1:0] idx,
                           input logic [stg_pkg::CfgDataW-1:0]  data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [stg_pkg::CfgDataW-1:0] step_w,
                               input logic [stg_pkg::CfgDataW-1:0] amp_w,
                               input logic [stg_pkg::CfgDataW-1:0] count_w);
    write_reg(stg_pkg::CFG_PHASE_STEP, step_w);
    write_reg(stg_pkg::CFG_AMPLITUDE, amp_w);
    write_reg(stg_pkg::CFG_SAMPLE_COUNT, count_w);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Result side: random stalls, eager stretches and one long hold-off on request
  initial begin
    int gap;
    int served;
    bit held;
    out_ch.ready = 1'b0;
    served = 0;
    held   = 1'b0;
    @(negedge clk);
    forever begin
      if (served % 64 == 0) receiver_eager = ($urandom_range(0, 3) == 0);
      gap = receiver_eager ? 0 : $urandom_range(0, 3);
      if (hold_request && !held) begin
        gap  = HoldCycles;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_sample(out_ch.sample, out_ch.last);
      served++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("sine_tone_generator_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [stg_pkg::CfgDataW-1:0] step_w;
    logic [stg_pkg::CfgDataW-1:0] amp_w;
    logic [stg_pkg::CfgDataW-1:0] count_w;
    int span;
    int phase_no;
    logic restart;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    hold_request  = 1'b0;
    sender_eager  = 1'b0;
    produced      = 0;
    settings      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values give a zero-length burst: ticks produce nothing
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // Quarter-turn steps hit every quadrant boundary; high write bits are dropped
    write_reg(CfgSpareIndex, '1);
    apply_setting(32'h4000_0000, 32'hFFFF_FFFF, 32'hFF00_0005);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    settle();

    // Full-scale step wraps the phase every tick
    apply_setting(32'hFFFF_FFFF, 32'd1, 32'd3);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    settle();

    // Longest burst, then lower the count under what was already emitted
    apply_setting(32'h8000_0000, 32'h7FFF, 32'h00FF_FFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();
    write_reg(stg_pkg::CFG_SAMPLE_COUNT, 32'd2);
    cfg_we <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // Silent amplitude, then a frozen phase with a one-sample burst
    apply_setting(32'h0123_4567, 32'd0, 32'd2);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
    apply_setting(32'd0, 32'h5555, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);

    // Random settings, mostly running bursts with the occasional restart
    produced = 0;
    phase_no = 0;
    while (produced < RandomGoal) begin
      settle();
      case ($urandom_range(0, 7))
        0:       step_w = '0;
        1:       step_w = '1;
        default: step_w = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       amp_w = '0;
        1:       amp_w = 32'h7FFF | ($urandom << stg_pkg::AmplitudeW);
        default: amp_w = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       count_w = $urandom << stg_pkg::SampleCountW;
        1:       count_w = 32'h00FF_FFFF | ($urandom << stg_pkg::SampleCountW);
        2:       count_w = $urandom;
        default: count_w = 32'($urandom_range(1, 48)) | ($urandom << stg_pkg::SampleCountW);
      endcase
      span = $urandom_range(10, 80);
      // Hold the result side off for a long stretch while requests keep coming
      if (phase_no == 3) begin
        count_w      = 32'h00FF_FFFF;
        span         = 120;
        hold_request = 1'b1;
      end
      apply_setting(step_w, amp_w, count_w);
      sender_eager = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        if (tracker.burst_done()) restart = $urandom_range(0, 1);
        else restart = ($urandom_range(0, 24) == 0);
        send_tick(restart);
      end
      phase_no++;
    end

    settle();
    repeat (TailCycles) @(negedge clk);
    $display("covered %0d tick requests and %0d restarts over %0d register settings;",
             tracker.ticks, tracker.restarts, settings);
    $display("checked %0d samples, %0d of them burst ends", tracker.checked, tracker.lasts);
    if (tracker.clean()) begin
      $display("sine_tone_generator_unit_tb: clean");
    end else begin
      $display("sine_tone_generator_unit_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/stg_pkg.sv
rtl/core/stg_if.sv
rtl/core/stg_queue.sv
rtl/core/stg_front.sv
rtl/core/stg_back.sv
rtl/core/sine_tone_generator_unit.sv
rtl/core/stg_checker.sv
tb/sine_tone_generator_unit_tb.sv
